>>> rtl/sdps_pkg.sv
// Types, codes and constants shared by the scan, detect and pick sequencer.
`timescale 1ns / 1ps

package sdps_pkg;

    localparam int WAIT_COUNT_WIDTH = 16;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DETECT_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INIT_WAIT_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CMD_WAIT_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SETTLE_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCAN_HEIGHT      = 3'd4;

    localparam logic [7:0]  THRESHOLD_RESET   = 8'd19;
    localparam logic [15:0] INIT_WAIT_RESET   = 16'd100;
    localparam logic [15:0] CMD_WAIT_RESET    = 16'd50;
    localparam logic [15:0] SETTLE_RESET      = 16'd1000;
    localparam logic [8:0]  SCAN_HEIGHT_RESET = 9'd150;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_SUCTION = 2'd2;

    localparam logic [8:0] POS_X_HOME   = 9'd200;
    localparam logic [7:0] POS_Y_HOME   = 8'd156;
    localparam logic [7:0] POS_Y_WRAP   = 8'd100;
    localparam logic [7:0] STEP_Y       = 8'd10;
    localparam logic [8:0] STEP_X       = 9'd15;
    localparam logic [8:0] POS_X_LIMIT  = 9'd320;
    localparam logic [8:0] ALIGN_X      = 9'd60;
    localparam logic [7:0] ALIGN_Y      = 8'd5;
    localparam logic [8:0] PICK_DROP    = 9'd125;
    localparam logic [8:0] RISE_Z       = 9'd100;
    localparam logic [7:0] LAST_DIST_RESET = 8'd25;

    typedef struct packed {
        logic       request;
        logic       distance_ok;
        logic [7:0] distance_mm;
    } t_in;

    typedef struct packed {
        logic [1:0]        cmd_kind;
        logic [8:0]        target_x;
        logic signed [7:0] target_y;
        logic [8:0]        target_z;
        logic              cube_seen;
        logic              running;
        logic              request_done;
    } t_out;

endpackage

>>> rtl/scan_detect_pick_sequencer.sv
// Scan, detect and pick sequencer: phase machine, raster position and output register.
`timescale 1ns / 1ps

// Each input transaction is one time-base tick and yields exactly one output transaction
// carrying the command of that tick (none, move or suction on) and the status flags. The
// phase machine and raster position are combinational between the input handshake and
// the output register, so a tick is taken every cycle, its output registered for the
// cycle after; a full output register held downstream is the only stall. Configuration
// writes go straight into the registers and should be made while no tick is in flight.
module scan_detect_pick_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdps_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [sdps_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sdps_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sdps_pkg::t_out                      o_out
);

    localparam int CW = sdps_pkg::WAIT_COUNT_WIDTH;

    localparam logic [3:0] PH_INIT    = 4'd0;
    localparam logic [3:0] PH_IDLE    = 4'd1;
    localparam logic [3:0] PH_MOVE    = 4'd2;
    localparam logic [3:0] PH_CMDWAIT = 4'd3;
    localparam logic [3:0] PH_READ    = 4'd4;
    localparam logic [3:0] PH_ALIGN   = 4'd5;
    localparam logic [3:0] PH_DESCEND = 4'd6;
    localparam logic [3:0] PH_SUCTION = 4'd7;
    localparam logic [3:0] PH_RISE    = 4'd8;

    logic [7:0]    r_threshold;
    logic [15:0]   r_init_wait;
    logic [15:0]   r_cmd_wait;
    logic [15:0]   r_settle;
    logic [8:0]    r_scan_height;

    logic [3:0]    r_phase, n_phase;
    logic [CW-1:0] r_wait, n_wait;
    logic [8:0]    r_pos_x, n_pos_x;
    logic [7:0]    r_pos_y, n_pos_y;
    logic [8:0]    r_pos_z, n_pos_z;
    logic [7:0]    r_last_dist, n_last_dist;
    logic          r_cube_flag, n_cube_flag;
    logic          r_run_flag, n_run_flag;

    logic           r_out_valid;
    sdps_pkg::t_out r_out, n_out;

    logic          in_accept;
    logic [CW-1:0] lim;
    logic [CW-1:0] wait_inc;
    logic [CW:0]   wait_inc_wide;
    logic          eq_hit;
    logic          gt_hit;
    logic [7:0]    step_y;
    logic [8:0]    step_x;
    logic [1:0]    kind;
    logic          done;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        case (r_phase)
            PH_INIT:    lim = CW'(r_init_wait);
            PH_CMDWAIT: lim = CW'(r_cmd_wait);
            default:    lim = CW'(r_settle);
        endcase
        wait_inc      = r_wait + 1'b1;
        wait_inc_wide = {1'b0, r_wait} + 1'b1;
        eq_hit        = (wait_inc == lim);
        gt_hit        = (wait_inc_wide > {1'b0, lim});
    end

    always_comb begin
        step_y = r_pos_y + sdps_pkg::STEP_Y;
        step_x = r_pos_x;
        if (step_y == sdps_pkg::POS_Y_WRAP) begin
            step_y = sdps_pkg::POS_Y_HOME;
            step_x = r_pos_x + sdps_pkg::STEP_X;
        end
        if (step_x >= sdps_pkg::POS_X_LIMIT) begin
            step_x = sdps_pkg::POS_X_HOME;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_pos_z     = r_pos_z;
        n_last_dist = r_last_dist;
        n_cube_flag = r_cube_flag;
        n_run_flag  = r_run_flag;
        kind        = sdps_pkg::CMD_NONE;
        done        = 1'b0;
        case (r_phase)
            PH_INIT: begin
                n_wait = eq_hit ? '0 : wait_inc;
                if (eq_hit) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (i_in.request) begin
                    n_pos_x    = sdps_pkg::POS_X_HOME;
                    n_pos_y    = sdps_pkg::POS_Y_HOME;
                    n_pos_z    = r_scan_height;
                    n_run_flag = 1'b1;
                    n_phase    = PH_MOVE;
                end
            end
            PH_MOVE: begin
                n_pos_x = step_x;
                n_pos_y = step_y;
                kind    = sdps_pkg::CMD_MOVE;
                n_phase = PH_CMDWAIT;
            end
            PH_CMDWAIT: begin
                n_wait = eq_hit ? '0 : wait_inc;
                if (eq_hit) begin
                    n_phase = PH_READ;
                end
            end
            PH_READ: begin
                if (i_in.distance_ok) begin
                    if (r_last_dist <= r_threshold && i_in.distance_mm <= r_threshold) begin
                        n_cube_flag = 1'b1;
                        n_phase     = PH_ALIGN;
                    end else begin
                        n_last_dist = i_in.distance_mm;
                        n_phase     = PH_MOVE;
                    end
                end
            end
            PH_ALIGN: begin
                n_pos_x = r_pos_x + sdps_pkg::ALIGN_X;
                n_pos_y = r_pos_y + sdps_pkg::ALIGN_Y;
                kind    = sdps_pkg::CMD_MOVE;
                n_phase = PH_DESCEND;
            end
            PH_DESCEND: begin
                n_wait = gt_hit ? '0 : wait_inc_wide[CW-1:0];
                if (gt_hit) begin
                    n_pos_z = r_scan_height - sdps_pkg::PICK_DROP;
                    kind    = sdps_pkg::CMD_MOVE;
                    n_phase = PH_SUCTION;
                end
            end
            PH_SUCTION: begin
                n_wait = gt_hit ? '0 : wait_inc_wide[CW-1:0];
                if (gt_hit) begin
                    kind    = sdps_pkg::CMD_SUCTION;
                    n_phase = PH_RISE;
                end
            end
            PH_RISE: begin
                n_wait = eq_hit ? '0 : wait_inc;
                if (eq_hit) begin
                    n_pos_z = sdps_pkg::RISE_Z;
                    kind    = sdps_pkg::CMD_MOVE;
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_out.cmd_kind     = kind;
        n_out.target_x     = (kind == sdps_pkg::CMD_MOVE) ? n_pos_x : 9'd0;
        n_out.target_y     = (kind == sdps_pkg::CMD_MOVE) ? signed'(n_pos_y) : 8'sd0;
        n_out.target_z     = (kind == sdps_pkg::CMD_MOVE) ? n_pos_z : 9'd0;
        n_out.cube_seen    = n_cube_flag;
        n_out.running      = n_run_flag;
        n_out.request_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= sdps_pkg::THRESHOLD_RESET;
            r_init_wait   <= sdps_pkg::INIT_WAIT_RESET;
            r_cmd_wait    <= sdps_pkg::CMD_WAIT_RESET;
            r_settle      <= sdps_pkg::SETTLE_RESET;
            r_scan_height <= sdps_pkg::SCAN_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdps_pkg::CFG_DETECT_THRESHOLD: r_threshold   <= i_cfg_wdata[7:0];
                sdps_pkg::CFG_INIT_WAIT_TICKS:  r_init_wait   <= i_cfg_wdata;
                sdps_pkg::CFG_CMD_WAIT_TICKS:   r_cmd_wait    <= i_cfg_wdata;
                sdps_pkg::CFG_SETTLE_TICKS:     r_settle      <= i_cfg_wdata;
                sdps_pkg::CFG_SCAN_HEIGHT:      r_scan_height <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_wait      <= '0;
            r_pos_x     <= sdps_pkg::POS_X_HOME;
            r_pos_y     <= sdps_pkg::POS_Y_HOME;
            r_pos_z     <= sdps_pkg::SCAN_HEIGHT_RESET;
            r_last_dist <= sdps_pkg::LAST_DIST_RESET;
            r_cube_flag <= 1'b0;
            r_run_flag  <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_pos_z     <= n_pos_z;
            r_last_dist <= n_last_dist;
            r_cube_flag <= n_cube_flag;
            r_run_flag  <= n_run_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_done_is_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.request_done |-> o_out.cmd_kind == sdps_pkg::CMD_MOVE)
        else $error("done pulse without a move transaction");

    a_idle_targets_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.cmd_kind != sdps_pkg::CMD_MOVE |->
            o_out.target_x == 9'd0 && o_out.target_y == 8'sd0 && o_out.target_z == 9'd0)
        else $error("target fields set without a move");

    a_cube_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cube_flag |=> r_cube_flag)
        else $error("cube flag cleared");

    a_busy_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_INIT && r_phase != PH_IDLE |-> r_run_flag)
        else $error("sequence active without an accepted request");
`endif

endmodule

>>> tb/scan_detect_pick_sequencer_tb.sv
// Self-checking testbench for the scan, detect and pick sequencer.
`timescale 1ns / 1ps

module scan_detect_pick_sequencer_tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_TICKS = 600;
    localparam int REPORT_LIMIT = 200;
    localparam int CFG_W        = sdps_pkg::CFG_DATA_WIDTH;

    typedef enum logic [3:0] {
        ST_STARTUP,
        ST_IDLE,
        ST_MOVE,
        ST_SCAN_WAIT,
        ST_SAMPLE,
        ST_ALIGN,
        ST_LOWER,
        ST_GRIP,
        ST_LIFT
    } t_seq_phase;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [sdps_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [sdps_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    sdps_pkg::t_in                        i_in;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    sdps_pkg::t_out                       o_out;

    logic [7:0]  cfg_threshold;
    logic [15:0] cfg_init_wait;
    logic [15:0] cfg_cmd_wait;
    logic [15:0] cfg_settle;
    logic [8:0]  cfg_scan_height;

    t_seq_phase  seq_phase;
    logic [15:0] tick_count;
    logic [8:0]  pos_x;
    logic [7:0]  pos_y;
    logic [8:0]  pos_z;
    logic [7:0]  last_dist;
    logic        cube_flag;
    logic        run_flag;

    sdps_pkg::t_out expected_ticks[$];
    sdps_pkg::t_out want_tick;
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   no_idle = 1'b0;

    scan_detect_pick_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit count_reaches(input logic [15:0] limit);
        tick_count = tick_count + 16'd1;
        if (tick_count == limit) begin
            tick_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit count_exceeds(input logic [15:0] limit);
        logic [16:0] next_count;
        next_count = {1'b0, tick_count} + 17'd1;
        if (next_count > {1'b0, limit}) begin
            tick_count = '0;
            return 1'b1;
        end
        tick_count = next_count[15:0];
        return 1'b0;
    endfunction

    task automatic advance_sequencer(input sdps_pkg::t_in tick);
        sdps_pkg::t_out res;
        logic [1:0]     kind;
        logic           done;
        kind = sdps_pkg::CMD_NONE;
        done = 1'b0;
        case (seq_phase)
            ST_STARTUP: begin
                if (count_reaches(cfg_init_wait)) seq_phase = ST_IDLE;
            end
            ST_IDLE: begin
                if (tick.request) begin
                    pos_x = sdps_pkg::POS_X_HOME;
                    pos_y = sdps_pkg::POS_Y_HOME;
                    pos_z = cfg_scan_height;
                    run_flag = 1'b1;
                    seq_phase = ST_MOVE;
                end
            end
            ST_MOVE: begin
                pos_y = pos_y + sdps_pkg::STEP_Y;
                if (pos_y == sdps_pkg::POS_Y_WRAP) begin
                    pos_y = sdps_pkg::POS_Y_HOME;
                    pos_x = pos_x + sdps_pkg::STEP_X;
                end
                if (pos_x >= sdps_pkg::POS_X_LIMIT) pos_x = sdps_pkg::POS_X_HOME;
                kind = sdps_pkg::CMD_MOVE;
                seq_phase = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                if (count_reaches(cfg_cmd_wait)) seq_phase = ST_SAMPLE;
            end
            ST_SAMPLE: begin
                if (tick.distance_ok) begin
                    if (last_dist <= cfg_threshold && tick.distance_mm <= cfg_threshold) begin
                        cube_flag = 1'b1;
                        seq_phase = ST_ALIGN;
                    end else begin
                        last_dist = tick.distance_mm;
                        seq_phase = ST_MOVE;
                    end
                end
            end
            ST_ALIGN: begin
                pos_x = pos_x + sdps_pkg::ALIGN_X;
                pos_y = pos_y + sdps_pkg::ALIGN_Y;
                kind = sdps_pkg::CMD_MOVE;
                seq_phase = ST_LOWER;
            end
            ST_LOWER: begin
                if (count_exceeds(cfg_settle)) begin
                    pos_z = cfg_scan_height - sdps_pkg::PICK_DROP;
                    kind = sdps_pkg::CMD_MOVE;
                    seq_phase = ST_GRIP;
                end
            end
            ST_GRIP: begin
                if (count_exceeds(cfg_settle)) begin
                    kind = sdps_pkg::CMD_SUCTION;
                    seq_phase = ST_LIFT;
                end
            end
            ST_LIFT: begin
                if (count_reaches(cfg_settle)) begin
                    pos_z = sdps_pkg::RISE_Z;
                    kind = sdps_pkg::CMD_MOVE;
                    done = 1'b1;
                    seq_phase = ST_IDLE;
                end
            end
            default: begin
                seq_phase = ST_IDLE;
            end
        endcase
        res.cmd_kind     = kind;
        res.target_x     = (kind == sdps_pkg::CMD_MOVE) ? pos_x : '0;
        res.target_y     = (kind == sdps_pkg::CMD_MOVE) ? pos_y : '0;
        res.target_z     = (kind == sdps_pkg::CMD_MOVE) ? pos_z : '0;
        res.cube_seen    = cube_flag;
        res.running      = run_flag;
        res.request_done = done;
        expected_ticks.push_back(res);
    endtask

    function automatic void check_field(input string name, input logic signed [9:0] want,
                                        input logic signed [9:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                fail_count++;
                $error("unexpected output transaction: %p", o_out);
            end else begin
                want_tick = expected_ticks.pop_front();
                check_field("cmd_kind", want_tick.cmd_kind, o_out.cmd_kind);
                check_field("target_x", want_tick.target_x, o_out.target_x);
                check_field("target_y", want_tick.target_y, o_out.target_y);
                check_field("target_z", want_tick.target_z, o_out.target_z);
                check_field("cube_seen", want_tick.cube_seen, o_out.cube_seen);
                check_field("running", want_tick.running, o_out.running);
                check_field("request_done", want_tick.request_done, o_out.request_done);
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (!no_idle && $urandom_range(0, 1) == 1) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_tick(input logic req, input logic ok, input logic [7:0] sample_mm);
        sdps_pkg::t_in tick;
        tick.request     = req;
        tick.distance_ok = ok;
        tick.distance_mm = sample_mm;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_sequencer(tick);
    endtask

    task automatic tick_while(input t_seq_phase ph, input logic req, input logic ok,
                              input logic [7:0] sample_mm);
        while (seq_phase == ph) send_tick(req, ok, sample_mm);
    endtask

    task automatic sample_after_move(input logic [7:0] sample_mm);
        tick_while(ST_MOVE, 1'b1, 1'b1, 8'd0);
        tick_while(ST_SCAN_WAIT, 1'b1, 1'b1, 8'd0);
        send_tick(1'b1, 1'b1, sample_mm);
    endtask

    task automatic finish_run();
        while (seq_phase != ST_IDLE) send_tick(1'b0, 1'b1, 8'd0);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sdps_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [sdps_pkg::CFG_DATA_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sdps_pkg::CFG_DETECT_THRESHOLD: cfg_threshold   = value[7:0];
            sdps_pkg::CFG_INIT_WAIT_TICKS:  cfg_init_wait   = value;
            sdps_pkg::CFG_CMD_WAIT_TICKS:   cfg_cmd_wait    = value;
            sdps_pkg::CFG_SETTLE_TICKS:     cfg_settle      = value;
            sdps_pkg::CFG_SCAN_HEIGHT:      cfg_scan_height = value[8:0];
            default: ;
        endcase
    endtask

    task automatic test_startup();
        tick_while(ST_STARTUP, 1'b1, 1'b1, 8'd255);
        send_tick(1'b0, 1'b0, 8'd0);
        send_tick(1'b0, 1'b1, 8'd0);
    endtask

    task automatic test_default_pick();
        drain_results();
        write_reg(sdps_pkg::CFG_SETTLE_TICKS, 16'd50);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd19);
        sample_after_move(8'd20);
        sample_after_move(8'd0);
        sample_after_move(8'd19);
        while (seq_phase != ST_IDLE) send_tick(1'b1, 1'b1, 8'd0);
        send_tick(1'b1, 1'b1, 8'd0);
        finish_run();
    endtask

    task automatic test_threshold_edges();
        drain_results();
        write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd0);
        write_reg(sdps_pkg::CFG_CMD_WAIT_TICKS, 16'd1);
        write_reg(sdps_pkg::CFG_SETTLE_TICKS, 16'd1);
        write_reg(sdps_pkg::CFG_INIT_WAIT_TICKS, 16'd1);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd1);
        tick_while(ST_MOVE, 1'b1, 1'b1, 8'd0);
        tick_while(ST_SCAN_WAIT, 1'b1, 1'b1, 8'd0);
        send_tick(1'b1, 1'b0, 8'd0);
        send_tick(1'b1, 1'b0, 8'd255);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd0);
        finish_run();
        drain_results();
        write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd255);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd255);
        finish_run();
    endtask

    task automatic test_scan_height_change();
        drain_results();
        write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd40);
        write_reg(sdps_pkg::CFG_SCAN_HEIGHT, 16'd400);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd200);
        tick_while(ST_MOVE, 1'b1, 1'b1, 8'd0);
        drain_results();
        write_reg(sdps_pkg::CFG_SCAN_HEIGHT, 16'd130);
        tick_while(ST_SCAN_WAIT, 1'b1, 1'b1, 8'd0);
        send_tick(1'b1, 1'b1, 8'd10);
        sample_after_move(8'd10);
        finish_run();
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd0);
        finish_run();
    endtask

    task automatic test_long_waits();
        drain_results();
        no_idle = 1'b1;
        write_reg(sdps_pkg::CFG_CMD_WAIT_TICKS, 16'd100);
        write_reg(sdps_pkg::CFG_SETTLE_TICKS, 16'd40);
        write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd255);
        write_reg(sdps_pkg::CFG_INIT_WAIT_TICKS, 16'd65535);
        send_tick(1'b1, 1'b1, 8'd0);
        sample_after_move(8'd0);
        finish_run();
        no_idle = 1'b0;
    endtask

    task automatic test_random_ticks();
        int         ticks_sent;
        int         seg_len;
        int         low_pct;
        logic [7:0] sample_mm;
        ticks_sent = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            finish_run();
            drain_results();
            if (ticks_sent >= RANDOM_TICKS - 300) no_idle = 1'b1;
            case ($urandom_range(0, 4))
                0: write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd0);
                1: write_reg(sdps_pkg::CFG_DETECT_THRESHOLD, 16'd255);
                default: write_reg(sdps_pkg::CFG_DETECT_THRESHOLD,
                                   CFG_W'($urandom_range(5, 60)));
            endcase
            write_reg(sdps_pkg::CFG_CMD_WAIT_TICKS, CFG_W'($urandom_range(1, 4)));
            write_reg(sdps_pkg::CFG_SETTLE_TICKS, CFG_W'($urandom_range(1, 6)));
            case ($urandom_range(0, 3))
                0: write_reg(sdps_pkg::CFG_SCAN_HEIGHT, 16'd130);
                1: write_reg(sdps_pkg::CFG_SCAN_HEIGHT, 16'd400);
                default: write_reg(sdps_pkg::CFG_SCAN_HEIGHT,
                                   CFG_W'($urandom_range(130, 400)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(sdps_pkg::CFG_INIT_WAIT_TICKS, CFG_W'($urandom()));
            case ($urandom_range(0, 3))
                0: low_pct = 0;
                1: low_pct = 5;
                2: low_pct = 30;
                default: low_pct = 70;
            endcase
            seg_len = (low_pct == 0) ? 250 : $urandom_range(80, 200);
            for (int i = 0; i < seg_len; i++) begin
                if ($urandom_range(0, 99) < low_pct || cfg_threshold == 8'd255)
                    sample_mm = 8'($urandom_range(0, {24'd0, cfg_threshold}));
                else
                    sample_mm = 8'($urandom_range({24'd0, cfg_threshold} + 32'd1, 255));
                send_tick($urandom_range(0, 9) != 0, $urandom_range(0, 99) < 85, sample_mm);
                ticks_sent++;
            end
        end
        finish_run();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;

        cfg_threshold   = sdps_pkg::THRESHOLD_RESET;
        cfg_init_wait   = sdps_pkg::INIT_WAIT_RESET;
        cfg_cmd_wait    = sdps_pkg::CMD_WAIT_RESET;
        cfg_settle      = sdps_pkg::SETTLE_RESET;
        cfg_scan_height = sdps_pkg::SCAN_HEIGHT_RESET;
        seq_phase       = ST_STARTUP;
        tick_count      = '0;
        pos_x           = sdps_pkg::POS_X_HOME;
        pos_y           = sdps_pkg::POS_Y_HOME;
        pos_z           = sdps_pkg::SCAN_HEIGHT_RESET;
        last_dist       = sdps_pkg::LAST_DIST_RESET;
        cube_flag       = 1'b0;
        run_flag        = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_startup();
        test_default_pick();
        test_threshold_edges();
        test_scan_height_change();
        test_long_waits();
        test_random_ticks();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
